// ----- hdl/nfa_epsilon_closure_matcher_macros.svh -----
// ---------------------------------------------------------------------------
// nfa_epsilon_closure_matcher_macros.svh
// Assertion macros used by the NFA matcher sequencer (nfa_ctrl). They expand to nothing
// when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH
`define NFA_EPSILON_CLOSURE_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define NFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nfa matcher assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define NFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nfa matcher assertion failed");

`else

`define NFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/nfa_pkg.sv -----
// ---------------------------------------------------------------------------
// nfa_pkg
// Shared constants, command codes and controller/datapath interface types
// for the NFA epsilon-closure matcher.
// ---------------------------------------------------------------------------
package nfa_pkg;

    // Field widths of one input beat
    localparam int CMD_W      = 2;
    localparam int STATE_W    = 6;
    localparam int SYM_W      = 8;
    localparam int SYM_WIDE_W = 16;   // widest symbol the table may keep

    // Stream packing
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int SRC_LSB    = 0;
    localparam int DST_LSB    = 6;
    localparam int EPS_BIT    = 12;
    localparam int SYM_LSB    = 13;
    localparam int ACC_BIT    = 0;
    localparam int ANY_BIT    = 1;
    localparam int FULL_BIT   = 2;

    // APB port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_START_STATE = 1'b0;
    localparam logic REG_FINAL_STATE = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // take the input beat (clear, add, seed next set)
        logic pass_start;  // rewind table scan, clear growth flag
        logic issue;       // read table entry at scan index and advance
        logic close_mode;  // entries are applied as epsilon closure
        logic commit;      // next set becomes active set
        logic load_out;    // load the result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;  // table holds no entries
        logic last_issue;  // scan index points at the last entry
        logic pass_done;   // last entry of the pass is applied this cycle
        logic grew_any;    // closure pass added at least one state
        logic slot_free;   // result register can take a new beat
    } t_dp_sts;

endpackage

// ----- hdl/nfa_epsilon_closure_matcher.sv -----
// ---------------------------------------------------------------------------
// nfa_epsilon_closure_matcher
// Thompson NFA simulation over a byte stream: a bounded transition table,
// start and consume commands, and epsilon closure computed by repeated
// scans of the table.
//
//   Channel  | Dir | Handshake                  | Payload
//   ---------+-----+----------------------------+------------------------------
//   s_axis   | in  | i_s_axis_tvalid/o_..tready | tdata 24b, tuser 2b command
//   m_axis   | out | o_m_axis_tvalid/i_..tready | tdata 8b result flags
//   apb      | in  | psel/penable/pready        | paddr 3b, pwdata/prdata 32b
//
// Clear and add go from idle straight to the result state. Start runs P closure
// passes over the N table entries and consume one symbol move pass and then P
// closure passes (P at most one per newly reached state plus one); with an empty
// table both skip the scans and go to commit. The single table read port reads
// one entry per cycle. Reset is synchronous and clears the table count, the
// active set and both registers. A stalled result is held in the output
// register; the next result waits for it.
// ---------------------------------------------------------------------------
module nfa_epsilon_closure_matcher #(
    parameter int STATE_COUNT   = 64,
    parameter int TABLE_ENTRIES = 128,
    parameter int SYMBOL_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // src_state[5:0], dest_state[11:6], is_epsilon[12], symbol[20:13], zero[23:21]
    input  logic [nfa_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // command[1:0]
    input  logic [nfa_pkg::CMD_W-1:0]         i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // accepted[0], any_active[1], table_full[2], zero[7:3]
    output logic [nfa_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nfa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nfa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nfa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    nfa_pkg::t_dp_cmd             w_cmd;
    nfa_pkg::t_dp_sts             w_sts;
    logic [nfa_pkg::STATE_W-1:0]  w_start_state;
    logic [nfa_pkg::STATE_W-1:0]  w_final_state;

    // Configuration registers
    nfa_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_start_state (w_start_state),
        .o_final_state (w_final_state)
    );

    // Sequencer
    nfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_in_cmd   (i_s_axis_tuser),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Table, state sets and result register
    nfa_dpath #(
        .STATE_COUNT   (STATE_COUNT),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SYMBOL_BITS   (SYMBOL_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_cmd      (i_s_axis_tuser),
        .i_src_state   (i_s_axis_tdata[nfa_pkg::SRC_LSB +: nfa_pkg::STATE_W]),
        .i_dest_state  (i_s_axis_tdata[nfa_pkg::DST_LSB +: nfa_pkg::STATE_W]),
        .i_is_epsilon  (i_s_axis_tdata[nfa_pkg::EPS_BIT]),
        .i_symbol      (i_s_axis_tdata[nfa_pkg::SYM_LSB +: nfa_pkg::SYM_W]),
        .i_start_state (w_start_state),
        .i_final_state (w_final_state),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata)
    );

endmodule

// ----- hdl/nfa_cfg.sv -----
// ---------------------------------------------------------------------------
// nfa_cfg
// APB register file holding the start and final state numbers.
// ---------------------------------------------------------------------------
module nfa_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nfa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nfa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nfa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output logic [nfa_pkg::STATE_W-1:0]       o_start_state,
    output logic [nfa_pkg::STATE_W-1:0]       o_final_state
);

    logic [nfa_pkg::STATE_W-1:0] r_start_state;
    logic [nfa_pkg::STATE_W-1:0] r_final_state;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes, word address in paddr[2]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_final_state <= '0;
        end else if (w_wr) begin
            unique case (paddr[2])
                nfa_pkg::REG_START_STATE: r_start_state <= pwdata[nfa_pkg::STATE_W-1:0];
                nfa_pkg::REG_FINAL_STATE: r_final_state <= pwdata[nfa_pkg::STATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            nfa_pkg::REG_START_STATE: prdata = nfa_pkg::APB_DATA_W'(r_start_state);
            nfa_pkg::REG_FINAL_STATE: prdata = nfa_pkg::APB_DATA_W'(r_final_state);
            default:                  prdata = '0;
        endcase
    end

    assign o_start_state = r_start_state;
    assign o_final_state = r_final_state;

endmodule

// ----- hdl/nfa_dpath.sv -----
// ---------------------------------------------------------------------------
// nfa_dpath
// Transition table memory, entry count, active and next state sets, table
// scan index and result register. Applies one table entry per cycle.
// ---------------------------------------------------------------------------
module nfa_dpath #(
    parameter int STATE_COUNT   = 64,
    parameter int TABLE_ENTRIES = 128,
    parameter int SYMBOL_BITS   = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nfa_pkg::t_dp_cmd                  i_cmd,
    output nfa_pkg::t_dp_sts                  o_sts,
    input  logic [nfa_pkg::CMD_W-1:0]         i_in_cmd,
    input  logic [nfa_pkg::STATE_W-1:0]       i_src_state,
    input  logic [nfa_pkg::STATE_W-1:0]       i_dest_state,
    input  logic                              i_is_epsilon,
    input  logic [nfa_pkg::SYM_W-1:0]         i_symbol,
    input  logic [nfa_pkg::STATE_W-1:0]       i_start_state,
    input  logic [nfa_pkg::STATE_W-1:0]       i_final_state,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [nfa_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int SW = $clog2(STATE_COUNT);
    localparam int QW = ((SW > nfa_pkg::STATE_W) ? SW : nfa_pkg::STATE_W) + 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = 2 * nfa_pkg::STATE_W + 1 + SYMBOL_BITS;

    // Entry layout: {sym, eps, dst, src}
    localparam int E_DST = nfa_pkg::STATE_W;
    localparam int E_EPS = 2 * nfa_pkg::STATE_W;
    localparam int E_SYM = 2 * nfa_pkg::STATE_W + 1;

    // State number decode: range check and set index
    function automatic logic f_in_range(input logic [nfa_pkg::STATE_W-1:0] q);
        f_in_range = QW'(q) < QW'(STATE_COUNT);
    endfunction

    function automatic logic [SW-1:0] f_idx(input logic [nfa_pkg::STATE_W-1:0] q);
        logic [QW-1:0] q_ext;
        q_ext = QW'(q);
        f_idx = q_ext[SW-1:0];
    endfunction

    logic [EW-1:0]              r_mem [TABLE_ENTRIES];
    logic [EW-1:0]              r_rd_data;
    logic                       r_rd_vld;
    logic                       r_rd_last;
    logic [AW-1:0]              r_idx;
    logic [CW-1:0]              r_count;
    logic [CW-1:0]              n_count;
    logic [STATE_COUNT-1:0]     r_active;
    logic [STATE_COUNT-1:0]     r_next;
    logic [STATE_COUNT-1:0]     n_next;
    logic [SYMBOL_BITS-1:0]     r_sym;
    logic                       r_full;
    logic                       r_grew;
    logic                       r_out_valid;
    logic [nfa_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [nfa_pkg::OUT_DATA_W-1:0] w_out_data;

    logic [nfa_pkg::SYM_WIDE_W-1:0] w_sym_wide;
    logic [SYMBOL_BITS-1:0]     w_sym;
    logic                       w_is_full;
    logic                       w_add_ok;
    logic [nfa_pkg::STATE_W-1:0] w_e_src;
    logic [nfa_pkg::STATE_W-1:0] w_e_dst;
    logic                       w_e_eps;
    logic [SYMBOL_BITS-1:0]     w_e_sym;
    logic                       w_src_ok;
    logic                       w_dst_ok;
    logic                       w_move_hit;
    logic                       w_close_hit;
    logic                       w_grow_now;
    logic                       w_accepted;

    // Input symbol cut to the table's symbol width
    assign w_sym_wide = nfa_pkg::SYM_WIDE_W'(i_symbol);
    assign w_sym      = w_sym_wide[SYMBOL_BITS-1:0];
    assign w_is_full  = (r_count == CW'(TABLE_ENTRIES));
    assign w_add_ok   = i_cmd.accept && (i_in_cmd == nfa_pkg::CMD_ADD) && !w_is_full;

    // Table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_add_ok) begin
            r_mem[r_count[AW-1:0]] <= {w_sym, i_is_epsilon, i_dest_state, i_src_state};
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Fields of the entry being applied
    assign w_e_src = r_rd_data[nfa_pkg::STATE_W-1:0];
    assign w_e_dst = r_rd_data[E_EPS-1:E_DST];
    assign w_e_eps = r_rd_data[E_EPS];
    assign w_e_sym = r_rd_data[E_SYM +: SYMBOL_BITS];
    assign w_src_ok = f_in_range(w_e_src);
    assign w_dst_ok = f_in_range(w_e_dst);

    // Symbol move reads the old set, closure reads the set being built
    assign w_move_hit  = !i_cmd.close_mode && !w_e_eps && (w_e_sym == r_sym) && w_src_ok
                         && w_dst_ok && r_active[f_idx(w_e_src)];
    assign w_close_hit = i_cmd.close_mode && w_e_eps && w_src_ok && w_dst_ok
                         && r_next[f_idx(w_e_src)] && !r_next[f_idx(w_e_dst)];
    assign w_grow_now  = r_rd_vld && w_close_hit;

    // Next set update
    always_comb begin
        n_next = r_next;
        if (i_cmd.accept && (i_in_cmd == nfa_pkg::CMD_START)) begin
            n_next = '0;
            if (f_in_range(i_start_state)) begin
                n_next[f_idx(i_start_state)] = 1'b1;
            end
        end else if (i_cmd.accept && (i_in_cmd == nfa_pkg::CMD_CONSUME)) begin
            n_next = '0;
        end else if (r_rd_vld && (w_move_hit || w_close_hit)) begin
            n_next[f_idx(w_e_dst)] = 1'b1;
        end
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.accept && (i_in_cmd == nfa_pkg::CMD_CLEAR)) begin
            n_count = '0;
        end else if (w_add_ok) begin
            n_count = r_count + CW'(1);
        end
    end

    // Scan and set registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_active <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.commit) begin
                r_active <= r_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_next    <= n_next;
        r_rd_last <= o_sts.last_issue;
        if (i_cmd.accept) begin
            r_sym  <= w_sym;
            r_full <= (i_in_cmd == nfa_pkg::CMD_ADD) && w_is_full;
        end
        if (i_cmd.pass_start) begin
            r_idx  <= '0;
            r_grew <= 1'b0;
        end else begin
            if (i_cmd.issue) begin
                r_idx <= r_idx + AW'(1);
            end
            if (w_grow_now) begin
                r_grew <= 1'b1;
            end
        end
    end

    // Result register
    assign w_accepted = f_in_range(i_final_state) && r_active[f_idx(i_final_state)];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result flags, padding bits zero
    always_comb begin
        w_out_data                   = '0;
        w_out_data[nfa_pkg::ACC_BIT]  = w_accepted;
        w_out_data[nfa_pkg::ANY_BIT]  = |r_active;
        w_out_data[nfa_pkg::FULL_BIT] = r_full;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= w_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status back to the controller
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.last_issue = (CW'(r_idx) == (r_count - CW'(1)));
    assign o_sts.pass_done  = r_rd_vld && r_rd_last;
    assign o_sts.grew_any   = r_grew || w_grow_now;
    assign o_sts.slot_free  = !r_out_valid || i_out_ready;

endmodule

// ----- hdl/nfa_ctrl.sv -----
// ---------------------------------------------------------------------------
// nfa_ctrl
// Sequencer for the matcher: takes one beat, runs the symbol move pass (consume) and
// the epsilon closure passes (start, consume) over the table, then hands off the result.
// ---------------------------------------------------------------------------
`include "nfa_epsilon_closure_matcher_macros.svh"

module nfa_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [nfa_pkg::CMD_W-1:0]    i_in_cmd,
    output nfa_pkg::t_dp_cmd             o_cmd,
    input  nfa_pkg::t_dp_sts             i_sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOVE   = 3'd1;
    localparam logic [2:0] S_CLOSE  = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_iss;
    logic       n_iss;
    logic       w_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_fire     = i_in_valid && o_in_ready;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_iss   = r_iss;
        o_cmd   = '0;
        o_cmd.close_mode = (r_state == S_CLOSE);
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) begin
                    o_cmd.accept     = 1'b1;
                    o_cmd.pass_start = 1'b1;
                    case (i_in_cmd)
                        nfa_pkg::CMD_START: begin
                            n_state = i_sts.count_zero ? S_COMMIT : S_CLOSE;
                            n_iss   = !i_sts.count_zero;
                        end
                        nfa_pkg::CMD_CONSUME: begin
                            n_state = i_sts.count_zero ? S_COMMIT : S_MOVE;
                            n_iss   = !i_sts.count_zero;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_MOVE, S_CLOSE: begin
                o_cmd.issue = r_iss;
                if (r_iss && i_sts.last_issue) begin
                    n_iss = 1'b0;
                end
                if (i_sts.pass_done) begin
                    if ((r_state == S_MOVE) || i_sts.grew_any) begin
                        // another closure pass
                        o_cmd.pass_start = 1'b1;
                        n_iss            = 1'b1;
                        n_state          = S_CLOSE;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (i_sts.slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iss   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iss   <= n_iss;
        end
    end

    // Checks
    `NFA_ASSERT_NXT(a_fire_leaves_idle, i_clk, i_rst_n, w_fire, r_state != S_IDLE)
    `NFA_ASSERT_NXT(a_fin_to_idle, i_clk, i_rst_n, (r_state == S_FIN) && i_sts.slot_free, r_state == S_IDLE)
    `NFA_ASSERT_IMP(a_issue_in_scan, i_clk, i_rst_n, o_cmd.issue, (r_state == S_MOVE) || (r_state == S_CLOSE))
    `NFA_ASSERT_IMP(a_done_not_issuing, i_clk, i_rst_n, i_sts.pass_done, !r_iss)

endmodule
